[rtl/core/ida_pkg.sv]
// Shared types and constants for the implicit diffusion row assembler.
`default_nettype none
package ida_pkg;

	// Cell and neighbour marker codes
	typedef enum logic [1:0] {
		MK_FLUID    = 2'd0,
		MK_AIR      = 2'd1,
		MK_BOUNDARY = 2'd2,
		MK_OUTSIDE  = 2'd3
	} marker_t;

	// Configuration register indexes
	localparam logic [1:0] REG_COEF_X    = 2'd0;
	localparam logic [1:0] REG_COEF_Y    = 2'd1;
	localparam logic [1:0] REG_DIRICHLET = 2'd2;

	// Field widths
	localparam int COEF_W   = 31;
	localparam int VALUE_W  = 32;
	localparam int CENTER_W = 35;
	localparam int OFFD_W   = 32;
	localparam int RHS_W    = 48;
	localparam int PROD_W   = 64;
	localparam int IN_W     = 176;
	localparam int OUT_W    = 152;

	// 1.0 in Q16.16
	localparam logic [CENTER_W-1:0] FX_ONE = 35'd65536;
	// Rounding offset, half an LSB of Q16.16
	localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd32768;

	// Neighbour adds its axis coefficient to the diagonal
	function automatic logic adds_center(input logic [1:0] m, input logic dir);
		adds_center = (m == MK_FLUID) || (dir && (m == MK_BOUNDARY));
	endfunction

endpackage
`default_nettype wire

[rtl/core/implicit_diffusion_row_assembly.sv]
// Top level: pipelined five-point backward-Euler row assembler.
//
// Channel | Dir | Width | Contents
// s_axis  | in  | 176   | markers and values of one cell and its four neighbours
// m_axis  | out | 152   | centre, right and up coefficients, right-hand side
// cfg     | in  | 31    | coef_x, coef_y, dirichlet_mode writes
//
// Five register stages: input, products, rounding, partial sums, final sum
// with saturation. One cell per clock while the output is not stalled.
// Each stage moves on when the next one is empty or moving, so a stalled
// output only backs up the stages behind it. arst_n clears valid bits and
// coefficients and sets dirichlet_mode; payload registers are not reset.
`default_nettype none
module implicit_diffusion_row_assembly (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// cfg
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [ida_pkg::COEF_W-1:0] cfg_data,
	// input stream
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// cell_marker, left_marker, right_marker, down_marker, up_marker,
	// cell_value, left_value, right_value, down_value, up_value, zero pad
	input  wire logic [ida_pkg::IN_W-1:0]  s_axis_tdata,
	// output stream
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// center_coef, right_coef, up_coef, rhs_value, zero pad
	output logic [ida_pkg::OUT_W-1:0]      m_axis_tdata
);
	import ida_pkg::*;

	// Configuration registers
	logic [COEF_W-1:0] coef_x_q, coef_y_q;
	logic              dirichlet_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q    <= '0;
			coef_y_q    <= '0;
			dirichlet_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_X:    coef_x_q    <= cfg_data;
				REG_COEF_Y:    coef_y_q    <= cfg_data;
				REG_DIRICHLET: dirichlet_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage enables, back to front
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	assign en5 = !v_s5 || m_axis_tready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture the transaction
	logic [1:0]                cm_s1, lm_s1, rm_s1, dm_s1, um_s1;
	logic signed [VALUE_W-1:0] cv_s1, lv_s1, rv_s1, dv_s1, uv_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			cm_s1 <= s_axis_tdata[1:0];
			lm_s1 <= s_axis_tdata[3:2];
			rm_s1 <= s_axis_tdata[5:4];
			dm_s1 <= s_axis_tdata[7:6];
			um_s1 <= s_axis_tdata[9:8];
			cv_s1 <= s_axis_tdata[41:10];
			lv_s1 <= s_axis_tdata[73:42];
			rv_s1 <= s_axis_tdata[105:74];
			dv_s1 <= s_axis_tdata[137:106];
			uv_s1 <= s_axis_tdata[169:138];
		end
	end

	// Stage 2 logic: boundary products and coefficients
	logic fluid;
	logic add_l, add_r, add_d, add_u;
	logic bnd_l, bnd_r, bnd_d, bnd_u;
	logic signed [VALUE_W-1:0] cx_sgn, cy_sgn;
	logic signed [PROD_W-1:0]  prod_l, prod_r, prod_d, prod_u;
	logic [CENTER_W-1:0]       cx_ext, cy_ext, sum_x, sum_y;

	assign fluid  = (cm_s1 == MK_FLUID);
	assign add_l  = adds_center(lm_s1, dirichlet_q);
	assign add_r  = adds_center(rm_s1, dirichlet_q);
	assign add_d  = adds_center(dm_s1, dirichlet_q);
	assign add_u  = adds_center(um_s1, dirichlet_q);
	assign bnd_l  = fluid && dirichlet_q && (lm_s1 == MK_BOUNDARY);
	assign bnd_r  = fluid && dirichlet_q && (rm_s1 == MK_BOUNDARY);
	assign bnd_d  = fluid && dirichlet_q && (dm_s1 == MK_BOUNDARY);
	assign bnd_u  = fluid && dirichlet_q && (um_s1 == MK_BOUNDARY);
	assign cx_sgn = signed'({1'b0, coef_x_q});
	assign cy_sgn = signed'({1'b0, coef_y_q});
	assign prod_l = cx_sgn * lv_s1;
	assign prod_r = cx_sgn * rv_s1;
	assign prod_d = cy_sgn * dv_s1;
	assign prod_u = cy_sgn * uv_s1;
	assign cx_ext = {4'd0, coef_x_q};
	assign cy_ext = {4'd0, coef_y_q};

	// Per-axis diagonal contribution: none, one or two coefficients
	always_comb begin
		case ({add_l, add_r})
			2'b11:   sum_x = cx_ext << 1;
			2'b01,
			2'b10:   sum_x = cx_ext;
			default: sum_x = '0;
		endcase
		case ({add_d, add_u})
			2'b11:   sum_y = cy_ext << 1;
			2'b01,
			2'b10:   sum_y = cy_ext;
			default: sum_y = '0;
		endcase
	end

	logic signed [PROD_W-1:0]  pl_s2, pr_s2, pd_s2, pu_s2;
	logic signed [VALUE_W-1:0] cv_s2;
	logic [CENTER_W-1:0]       sx_s2, sy_s2;
	logic                      fluid_s2;
	logic signed [OFFD_W-1:0]  rc_s2, uc_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			pl_s2    <= bnd_l ? prod_l : '0;
			pr_s2    <= bnd_r ? prod_r : '0;
			pd_s2    <= bnd_d ? prod_d : '0;
			pu_s2    <= bnd_u ? prod_u : '0;
			cv_s2    <= cv_s1;
			sx_s2    <= sum_x;
			sy_s2    <= sum_y;
			fluid_s2 <= fluid;
			rc_s2    <= (fluid && rm_s1 == MK_FLUID) ? -cx_sgn : '0;
			uc_s2    <= (fluid && um_s1 == MK_FLUID) ? -cy_sgn : '0;
		end
	end

	// Stage 3: round products to Q16.16 (nearest, ties up) and build diagonal
	logic signed [PROD_W-1:0] rl_w, rr_w, rd_w, ru_w;
	assign rl_w = pl_s2 + RND_HALF;
	assign rr_w = pr_s2 + RND_HALF;
	assign rd_w = pd_s2 + RND_HALF;
	assign ru_w = pu_s2 + RND_HALF;

	logic signed [RHS_W-1:0]   tl_s3, tr_s3, td_s3, tu_s3;
	logic signed [VALUE_W-1:0] cv_s3;
	logic [CENTER_W-1:0]       cc_s3;
	logic signed [OFFD_W-1:0]  rc_s3, uc_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			tl_s3 <= rl_w[PROD_W-1:16];
			tr_s3 <= rr_w[PROD_W-1:16];
			td_s3 <= rd_w[PROD_W-1:16];
			tu_s3 <= ru_w[PROD_W-1:16];
			cv_s3 <= cv_s2;
			cc_s3 <= fluid_s2 ? (FX_ONE + sx_s2 + sy_s2) : FX_ONE;
			rc_s3 <= rc_s2;
			uc_s3 <= uc_s2;
		end
	end

	// Stage 4: partial sums of the right-hand side
	logic signed [RHS_W:0]    sa_s4;
	logic signed [RHS_W+1:0]  sb_s4;
	logic [CENTER_W-1:0]      cc_s4;
	logic signed [OFFD_W-1:0] rc_s4, uc_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			sa_s4 <= {tl_s3[RHS_W-1], tl_s3} + {tr_s3[RHS_W-1], tr_s3};
			sb_s4 <= {{2{td_s3[RHS_W-1]}}, td_s3} + {{2{tu_s3[RHS_W-1]}}, tu_s3}
				+ {{(RHS_W+2-VALUE_W){cv_s3[VALUE_W-1]}}, cv_s3};
			cc_s4 <= cc_s3;
			rc_s4 <= rc_s3;
			uc_s4 <= uc_s3;
		end
	end

	// Stage 5: final sum and saturation to 48 bits
	logic signed [RHS_W+2:0] tot_w;
	logic [RHS_W-1:0]        rhs_sat;
	assign tot_w = {{2{sa_s4[RHS_W]}}, sa_s4} + {sb_s4[RHS_W+1], sb_s4};

	always_comb begin
		if (!tot_w[RHS_W+2] && (|tot_w[RHS_W+1:RHS_W-1]))
			rhs_sat = {1'b0, {(RHS_W-1){1'b1}}};
		else if (tot_w[RHS_W+2] && !(&tot_w[RHS_W+1:RHS_W-1]))
			rhs_sat = {1'b1, {(RHS_W-1){1'b0}}};
		else
			rhs_sat = tot_w[RHS_W-1:0];
	end

	logic [CENTER_W-1:0]      cc_s5;
	logic signed [OFFD_W-1:0] rc_s5, uc_s5;
	logic [RHS_W-1:0]         rhs_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			cc_s5  <= cc_s4;
			rc_s5  <= rc_s4;
			uc_s5  <= uc_s4;
			rhs_s5 <= rhs_sat;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {5'd0, rhs_s5, uc_s5, rc_s5, cc_s5};

	// Checks
	a_full_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while output free");
	a_nonfluid_no_terms: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en2 && cm_s1 != MK_FLUID) |=>
		(pl_s2 == '0 && pr_s2 == '0 && pd_s2 == '0 && pu_s2 == '0))
		else $error("boundary term for non-fluid cell");
	a_right_coef: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (rc_s5 == '0 || rc_s5 == -cx_sgn))
		else $error("right coefficient out of range");
	a_center_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (cc_s5 >= FX_ONE))
		else $error("diagonal below one");

endmodule
`default_nettype wire
